### hw/rtl/x86enc_pkg.sv
// Package for the 16-bit x86 instruction encoder.
// Holds the form table, the instruction kinds and the queue entry type.
// Has no dependencies.
package x86enc_pkg;

   localparam int FORM_COUNT          = 54;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CODE_BYTES          = 4;

   localparam logic [15:0] REG_INDEX_MAX  = 16'd8;
   localparam logic [15:0] SHORT_JUMP_LEN = 16'd2;
   localparam logic [15:0] NEAR_JUMP_LEN  = 16'd3;

   localparam logic [7:0] MODRM_REG_REG = 8'hC0;
   localparam logic [7:0] MODRM_DIRECT  = 8'h06;
   localparam logic [7:0] MODRM_BX      = 8'h07;

   localparam logic [7:0] OP_PUSH   = 8'h50;
   localparam logic [7:0] OP_POP    = 8'h58;
   localparam logic [7:0] OP_MOVI   = 8'hB8;
   localparam logic [7:0] OP_RET    = 8'hC3;
   localparam logic [7:0] OP_RETF   = 8'hCB;
   localparam logic [7:0] OP_INT    = 8'hCD;
   localparam logic [7:0] OP_CALL   = 8'hE8;
   localparam logic [7:0] OP_JMP    = 8'hE9;
   localparam logic [7:0] OP_GRP_IMM = 8'h81;
   localparam logic [7:0] OP_GRP_F7 = 8'hF7;

   localparam logic [7:0] OP_MOV = 8'h89;
   localparam logic [7:0] OP_CMP = 8'h39;
   localparam logic [7:0] OP_ADD = 8'h01;
   localparam logic [7:0] OP_SUB = 8'h29;
   localparam logic [7:0] OP_AND = 8'h21;
   localparam logic [7:0] OP_OR  = 8'h09;
   localparam logic [7:0] OP_DIR = 8'h02;

   localparam logic [7:0] OP_JE  = 8'h74;
   localparam logic [7:0] OP_JNE = 8'h75;
   localparam logic [7:0] OP_JG  = 8'h7F;
   localparam logic [7:0] OP_JGE = 8'h7D;
   localparam logic [7:0] OP_JL  = 8'h7C;
   localparam logic [7:0] OP_JLE = 8'h7E;
   localparam logic [7:0] OP_JC  = 8'h72;
   localparam logic [7:0] OP_JNC = 8'h73;

   localparam logic [2:0] EXT_NONE = 3'd0;
   localparam logic [2:0] EXT_ADD  = 3'd0;
   localparam logic [2:0] EXT_OR   = 3'd1;
   localparam logic [2:0] EXT_NOT  = 3'd2;
   localparam logic [2:0] EXT_AND  = 3'd4;
   localparam logic [2:0] EXT_MUL  = 3'd4;
   localparam logic [2:0] EXT_SUB  = 3'd5;
   localparam logic [2:0] EXT_DIV  = 3'd6;
   localparam logic [2:0] EXT_CMP  = 3'd7;

   typedef enum logic [3:0] {
      KIND_ONE,
      KIND_REG1,
      KIND_INT,
      KIND_JS,
      KIND_JN,
      KIND_GRPI,
      KIND_GRPF,
      KIND_MOVI,
      KIND_RR,
      KIND_RM,
      KIND_MR,
      KIND_RRM,
      KIND_RMR
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  opcode;
      logic [2:0]  ext;
   } form_type;

   typedef struct packed {
      logic [CODE_BYTES-1:0][7:0] code;
      logic [1:0]                 last_index;
      logic                       bad;
   } entry_type;

   localparam form_type FORM_TABLE [FORM_COUNT] = '{
      '{KIND_REG1, OP_PUSH, EXT_NONE}, '{KIND_REG1, OP_POP, EXT_NONE},
      '{KIND_MOVI, OP_MOVI, EXT_NONE}, '{KIND_RR, OP_MOV, EXT_NONE},
      '{KIND_RM, OP_MOV | OP_DIR, EXT_NONE}, '{KIND_MR, OP_MOV, EXT_NONE},
      '{KIND_RRM, OP_MOV | OP_DIR, EXT_NONE}, '{KIND_RMR, OP_MOV, EXT_NONE},
      '{KIND_GRPI, OP_GRP_IMM, EXT_CMP}, '{KIND_RR, OP_CMP, EXT_NONE},
      '{KIND_RM, OP_CMP | OP_DIR, EXT_NONE}, '{KIND_MR, OP_CMP, EXT_NONE},
      '{KIND_RRM, OP_CMP | OP_DIR, EXT_NONE}, '{KIND_RMR, OP_CMP, EXT_NONE},
      '{KIND_ONE, OP_RET, EXT_NONE}, '{KIND_ONE, OP_RETF, EXT_NONE},
      '{KIND_INT, OP_INT, EXT_NONE},
      '{KIND_JN, OP_CALL, EXT_NONE}, '{KIND_JN, OP_JMP, EXT_NONE},
      '{KIND_JS, OP_JE, EXT_NONE}, '{KIND_JS, OP_JNE, EXT_NONE},
      '{KIND_JS, OP_JG, EXT_NONE}, '{KIND_JS, OP_JGE, EXT_NONE},
      '{KIND_JS, OP_JL, EXT_NONE}, '{KIND_JS, OP_JLE, EXT_NONE},
      '{KIND_JS, OP_JC, EXT_NONE}, '{KIND_JS, OP_JNC, EXT_NONE},
      '{KIND_GRPI, OP_GRP_IMM, EXT_ADD}, '{KIND_RR, OP_ADD, EXT_NONE},
      '{KIND_RM, OP_ADD | OP_DIR, EXT_NONE}, '{KIND_MR, OP_ADD, EXT_NONE},
      '{KIND_RRM, OP_ADD | OP_DIR, EXT_NONE}, '{KIND_RMR, OP_ADD, EXT_NONE},
      '{KIND_GRPI, OP_GRP_IMM, EXT_SUB}, '{KIND_RR, OP_SUB, EXT_NONE},
      '{KIND_RM, OP_SUB | OP_DIR, EXT_NONE}, '{KIND_MR, OP_SUB, EXT_NONE},
      '{KIND_RRM, OP_SUB | OP_DIR, EXT_NONE}, '{KIND_RMR, OP_SUB, EXT_NONE},
      '{KIND_GRPF, OP_GRP_F7, EXT_MUL}, '{KIND_GRPF, OP_GRP_F7, EXT_DIV},
      '{KIND_GRPF, OP_GRP_F7, EXT_NOT},
      '{KIND_GRPI, OP_GRP_IMM, EXT_AND}, '{KIND_RR, OP_AND, EXT_NONE},
      '{KIND_RM, OP_AND | OP_DIR, EXT_NONE}, '{KIND_MR, OP_AND, EXT_NONE},
      '{KIND_RRM, OP_AND | OP_DIR, EXT_NONE}, '{KIND_RMR, OP_AND, EXT_NONE},
      '{KIND_GRPI, OP_GRP_IMM, EXT_OR}, '{KIND_RR, OP_OR, EXT_NONE},
      '{KIND_RM, OP_OR | OP_DIR, EXT_NONE}, '{KIND_MR, OP_OR, EXT_NONE},
      '{KIND_RRM, OP_OR | OP_DIR, EXT_NONE}, '{KIND_RMR, OP_OR, EXT_NONE}
   };

   function automatic logic [2:0] reg_code(input logic [15:0] index);
      logic [15:0] dec;
      dec = index - 16'd1;
      return (index == 16'd0) ? 3'd0 : dec[2:0];
   endfunction

endpackage

### hw/rtl/x86enc_if.sv
// Channel interfaces of the 16-bit x86 instruction encoder.
// Request carries one instruction, response carries one code byte.
// Has no dependencies.
interface x86enc_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  action;
   logic [15:0] operand_a;
   logic [15:0] operand_b;
   logic [15:0] start_offset;

   modport source (output valid, action, operand_a, operand_b, start_offset, input ready);
   modport sink   (input valid, action, operand_a, operand_b, start_offset, output ready);
endinterface

interface x86enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_byte;
   logic       bad_form;

   modport source (output valid, code_byte, last_byte, bad_form, input ready);
   modport sink   (input valid, code_byte, last_byte, bad_form, output ready);
endinterface

### hw/rtl/x86enc_front.sv
// Front end of the encoder: classifies the form and builds all code bytes.
// Depends on x86enc_pkg and x86enc_req_if.
module x86enc_front import x86enc_pkg::*; (
   x86enc_req_if.sink  req_chan,
   input  logic [15:0] origin,
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_entry
);

   form_type    form;
   logic        known;
   logic        a_is_reg;
   logic        b_is_reg;
   logic        bad;
   logic [2:0]  ra;
   logic [2:0]  rb;
   logic [15:0] a;
   logic [15:0] b;
   logic [15:0] rel_short;
   logic [15:0] rel_near;
   logic [7:0]  op;
   logic [7:0]  grp_modrm;
   entry_type   entry;

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_entry     = entry;

   always_comb begin
      a     = req_chan.operand_a;
      b     = req_chan.operand_b;
      known = ({26'd0, req_chan.action} < FORM_COUNT);
      form  = FORM_TABLE[req_chan.action];
      op    = form.opcode;
      ra    = reg_code(a);
      rb    = reg_code(b);
      grp_modrm = MODRM_REG_REG | {2'b00, form.ext, ra};
      rel_short = a - origin - (req_chan.start_offset + SHORT_JUMP_LEN);
      rel_near  = a - origin - (req_chan.start_offset + NEAR_JUMP_LEN);
      a_is_reg = (form.kind == KIND_REG1) || (form.kind == KIND_GRPI) ||
                 (form.kind == KIND_GRPF) || (form.kind == KIND_MOVI) ||
                 (form.kind == KIND_RR) || (form.kind == KIND_RM) ||
                 (form.kind == KIND_RRM);
      b_is_reg = (form.kind == KIND_RR) || (form.kind == KIND_MR) ||
                 (form.kind == KIND_RMR);
      bad = !known || (a_is_reg && (a > REG_INDEX_MAX)) ||
            (b_is_reg && (b > REG_INDEX_MAX));

      entry.code       = '0;
      entry.code[0]    = op;
      entry.last_index = 2'd1;
      entry.bad        = 1'b0;
      case (form.kind)
         KIND_ONE: begin
            entry.last_index = 2'd0;
         end
         KIND_REG1: begin
            entry.code[0]    = op + {5'd0, ra};
            entry.last_index = 2'd0;
         end
         KIND_INT: begin
            entry.code[1] = a[7:0];
         end
         KIND_JS: begin
            entry.code[1] = rel_short[7:0];
         end
         KIND_JN: begin
            entry.code[1]    = rel_near[7:0];
            entry.code[2]    = rel_near[15:8];
            entry.last_index = 2'd2;
         end
         KIND_GRPI: begin
            entry.code[1]    = grp_modrm;
            entry.code[2]    = b[7:0];
            entry.code[3]    = b[15:8];
            entry.last_index = 2'd3;
         end
         KIND_GRPF: begin
            entry.code[1] = grp_modrm;
         end
         KIND_MOVI: begin
            entry.code[0]    = op + {5'd0, ra};
            entry.code[1]    = b[7:0];
            entry.code[2]    = b[15:8];
            entry.last_index = 2'd2;
         end
         KIND_RR: begin
            entry.code[1] = MODRM_REG_REG | {2'b00, rb, ra};
         end
         KIND_RM: begin
            entry.code[1]    = MODRM_DIRECT | {2'b00, ra, 3'b000};
            entry.code[2]    = b[7:0];
            entry.code[3]    = b[15:8];
            entry.last_index = 2'd3;
         end
         KIND_MR: begin
            entry.code[1]    = MODRM_DIRECT | {2'b00, rb, 3'b000};
            entry.code[2]    = a[7:0];
            entry.code[3]    = a[15:8];
            entry.last_index = 2'd3;
         end
         KIND_RRM: begin
            entry.code[1] = MODRM_BX | {2'b00, ra, 3'b000};
         end
         KIND_RMR: begin
            entry.code[1] = MODRM_BX | {2'b00, rb, 3'b000};
         end
         default: begin
            entry.last_index = 2'd0;
         end
      endcase

      if (bad) begin
         entry.code       = '0;
         entry.last_index = 2'd0;
         entry.bad        = 1'b1;
      end
   end

endmodule

### hw/rtl/x86enc_queue.sv
// Short queue of encoded instructions between the front and back ends.
// Depends on x86enc_pkg.
module x86enc_queue import x86enc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push;

   assign push_ready = (count_ff != COUNT_MAX);
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/x86enc_back.sv
// Back end of the encoder: sends the queued code bytes one per transfer.
// Depends on x86enc_pkg and x86enc_rsp_if.
module x86enc_back import x86enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   x86enc_rsp_if.source rsp_chan
);

   logic       valid_ff, valid_in;
   logic [1:0] index_ff, index_in;
   logic [7:0] code_byte_ff;
   logic       last_byte_ff;
   logic       bad_form_ff;
   logic       load;
   logic       is_last;

   assign load    = head_valid && (!valid_ff || rsp_chan.ready);
   assign is_last = (index_ff == head_entry.last_index);
   assign pop     = load && is_last;

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.code_byte = code_byte_ff;
   assign rsp_chan.last_byte = last_byte_ff;
   assign rsp_chan.bad_form  = bad_form_ff;

   always_comb begin
      valid_in = valid_ff;
      index_in = index_ff;
      if (load) begin
         valid_in = 1'b1;
         index_in = is_last ? 2'd0 : index_ff + 2'd1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_byte_ff <= head_entry.code[index_ff];
         last_byte_ff <= is_last;
         bad_form_ff  <= head_entry.bad;
      end
   end

endmodule

### hw/rtl/x86_16_instruction_encoder_core.sv
// Top level of the 16-bit x86 instruction encoder.
// Depends on x86enc_pkg, x86enc_if, x86enc_front, x86enc_queue and x86enc_back.
//
// Each transfer on req_chan carries one instruction: form number, two operands
// and the output offset of its first byte. The block answers with 1 to 4
// transfers on rsp_chan, one machine code byte each, the final one flagged by
// last_byte. An unknown form or a bad register index gives a single transfer
// with bad_form set and code byte zero.
// The front end encodes an instruction in the cycle it is accepted and writes
// it into a queue of QUEUE_DEPTH entries. The first byte passes through the
// queue storage and the back end's single output register before it is shown.
// That register sends one byte per cycle while the receiver is ready, and
// instructions follow back to back. When the receiver stalls, the current byte
// holds and the queue absorbs up to QUEUE_DEPTH instructions before
// req_chan.ready drops. The origin is written through csr_wr_en and csr_wr_data;
// the user must do so only while idle, which the block does not enforce. Reset
// empties the queue and the output register and sets the origin to 0.
module x86_16_instruction_encoder_core import x86enc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   x86enc_req_if.sink   req_chan,
   x86enc_rsp_if.source rsp_chan,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   logic [15:0] origin_ff, origin_in;
   logic        push_valid;
   logic        push_ready;
   entry_type   push_entry;
   logic        head_valid;
   entry_type   head_entry;
   logic        pop;

   assign origin_in = csr_wr_en ? csr_wr_data : origin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= 16'd0;
      end else begin
         origin_ff <= origin_in;
      end
   end

   x86enc_front u_front (
      .req_chan   (req_chan),
      .origin     (origin_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   x86enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   x86enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
